### rtl/x86d_pkg.sv
package x86d_pkg;

  localparam logic [5:0] MOV_RM_PREFIX   = 6'b100010;
  localparam logic [3:0] MOV_IMM_REG_PFX = 4'b1011;
  localparam logic [6:0] MOV_IMM_RM_PFX  = 7'b1100011;
  localparam logic [5:0] ALU_IMM_RM_PFX  = 6'b100000;
  localparam logic [3:0] JCC_PREFIX      = 4'b0111;
  localparam logic [3:0] LOOP_PREFIX     = 4'b1110;

  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  typedef enum logic [3:0] {
    CLS_MOV_RM      = 4'd0,
    CLS_MOV_IMM_REG = 4'd1,
    CLS_MOV_IMM_RM  = 4'd2,
    CLS_ALU_RM      = 4'd3,
    CLS_ALU_IMM_ACC = 4'd4,
    CLS_ALU_IMM_RM  = 4'd5,
    CLS_JCC         = 4'd6,
    CLS_LOOP        = 4'd7,
    CLS_ERROR       = 4'd8
  } instr_class_t;

  typedef enum logic [3:0] {
    ALU_ADD   = 4'd0,
    ALU_SUB   = 4'd1,
    ALU_CMP   = 4'd2,
    ALU_OTHER = 4'd3
  } alu_sel_t;

  localparam logic [2:0] ALU_FIELD_ADD = 3'd0;
  localparam logic [2:0] ALU_FIELD_SUB = 3'd5;
  localparam logic [2:0] ALU_FIELD_CMP = 3'd7;

  localparam logic [1:0] MOD_MEM_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8      = 2'd1;
  localparam logic [1:0] MOD_DISP16     = 2'd2;
  localparam logic [1:0] MOD_REGISTER   = 2'd3;
  localparam logic [2:0] RM_DIRECT      = 3'd6;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_IMM_LO  = 3'd4,
    PH_IMM_HI  = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         instr_class;
    logic [3:0]         op_select;
    logic               dir_bit;
    logic               wide_bit;
    logic [1:0]         mode_field;
    logic [2:0]         reg_field;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         instr_length;
    logic               reg_written;
    logic [15:0]        written_value;
  } out_item_t;

  typedef struct packed {
    logic              wr;
    logic              wide;
    logic [2:0]        dst_r;
    logic [REG_AW-1:0] dst_word;
    logic              src_is_reg;
    logic [2:0]        src_r;
    logic [REG_AW-1:0] src_word;
  } exec_req_t;

  function automatic instr_class_t class_of(logic [7:0] op);
    instr_class_t c;
    if (op[7:2] == MOV_RM_PREFIX) c = CLS_MOV_RM;
    else if (op[7:4] == MOV_IMM_REG_PFX) c = CLS_MOV_IMM_REG;
    else if (op[7:1] == MOV_IMM_RM_PFX) c = CLS_MOV_IMM_RM;
    else if (op[7:6] == 2'b00) c = op[2] ? CLS_ALU_IMM_ACC : CLS_ALU_RM;
    else if (op[7:2] == ALU_IMM_RM_PFX) c = CLS_ALU_IMM_RM;
    else if (op[7:4] == JCC_PREFIX) c = CLS_JCC;
    else if (op[7:4] == LOOP_PREFIX && op[3:2] == 2'b00) c = CLS_LOOP;
    else c = CLS_ERROR;
    return c;
  endfunction

  function automatic logic has_modrm(instr_class_t c);
    return c == CLS_MOV_RM || c == CLS_MOV_IMM_RM || c == CLS_ALU_RM ||
           c == CLS_ALU_IMM_RM;
  endfunction

  function automatic logic [1:0] disp_len(instr_class_t c, logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (c == CLS_JCC || c == CLS_LOOP) n = 2'd1;
    else if (has_modrm(c)) begin
      if (m[7:6] == MOD_DISP8) n = 2'd1;
      else if (m[7:6] == MOD_DISP16) n = 2'd2;
      else if (m[7:6] == MOD_MEM_NODISP && m[2:0] == RM_DIRECT) n = 2'd2;
    end
    return n;
  endfunction

  function automatic logic [1:0] imm_len(instr_class_t c, logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (c == CLS_MOV_IMM_REG) n = op[3] ? 2'd2 : 2'd1;
    else if (c == CLS_MOV_IMM_RM || c == CLS_ALU_IMM_ACC) n = op[0] ? 2'd2 : 2'd1;
    else if (c == CLS_ALU_IMM_RM) n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
    return n;
  endfunction

  function automatic phase_t next_phase(phase_t p, logic [7:0] op, logic [7:0] m);
    instr_class_t c;
    logic [1:0]   dl;
    logic [1:0]   il;
    phase_t       np;
    c  = class_of(op);
    dl = disp_len(c, m);
    il = imm_len(c, op);
    if (p < PH_MODRM && has_modrm(c)) np = PH_MODRM;
    else if (p < PH_DISP_LO && dl >= 2'd1) np = PH_DISP_LO;
    else if (p < PH_DISP_HI && dl == 2'd2) np = PH_DISP_HI;
    else if (p < PH_IMM_LO && il >= 2'd1) np = PH_IMM_LO;
    else if (p < PH_IMM_HI && il == 2'd2) np = PH_IMM_HI;
    else np = PH_DONE;
    return np;
  endfunction

  function automatic alu_sel_t alu_code(logic [2:0] x);
    alu_sel_t s;
    case (x)
      ALU_FIELD_ADD: s = ALU_ADD;
      ALU_FIELD_SUB: s = ALU_SUB;
      ALU_FIELD_CMP: s = ALU_CMP;
      default: s = ALU_OTHER;
    endcase
    return s;
  endfunction

endpackage

### rtl/x86d_ifs.sv
interface x86d_in_if;
  logic               valid;
  logic               ready;
  x86d_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface x86d_out_if;
  logic                valid;
  logic                ready;
  x86d_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### rtl/x86_16_instruction_decoder_core.sv
// Byte-serial decoder for a subset of 8086 code (mov, add/sub/cmp, jcc, loop/jcxz).
// One code byte is accepted per clock while the result side keeps up; the
// decoded instruction passes from its final byte into the register-file read
// stage (the file is a synchronous memory with two read ports and one write
// port) and then into the output register. With
// exec_enable set, mov to a register is written back to the file as the
// result leaves the read stage, and a read in the same cycle sees that write.
// Unknown opcodes give an error of length 1 at once; last_byte on a byte that
// does not finish an instruction gives an error of the length taken so far.
module x86_16_instruction_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  x86d_in_if.sink     code,
  x86d_out_if.source  decoded
);

  logic exec_enable;

  x86d_pkg::phase_t phase;
  x86d_pkg::phase_t phase_next;
  logic [7:0]  first_byte;
  logic [7:0]  first_byte_next;
  logic [7:0]  modrm_byte;
  logic [7:0]  modrm_byte_next;
  logic [15:0] disp_accum;
  logic [15:0] disp_accum_next;
  logic [15:0] imm_accum;
  logic [15:0] imm_accum_next;
  logic [2:0]  bytes_taken;
  logic [2:0]  bytes_taken_next;

  logic             acc;
  logic             done;
  logic             fail;
  x86d_pkg::phase_t np;

  x86d_pkg::out_item_t res_item;
  x86d_pkg::exec_req_t res_req;

  logic                a_valid;
  x86d_pkg::out_item_t a_item;
  x86d_pkg::exec_req_t a_req;
  logic                a_adv;
  logic                a_free;
  logic                load_a;
  x86d_pkg::out_item_t a_out;

  logic                o_valid;
  x86d_pkg::out_item_t o_item;

  logic [15:0] regs [x86d_pkg::REG_COUNT];
  logic [x86d_pkg::REG_COUNT-1:0] reg_valid;
  logic [15:0] rdata0;
  logic [15:0] rdata1;
  logic        rok0;
  logic        rok1;
  logic        we;
  logic [x86d_pkg::REG_AW-1:0] waddr;
  logic [15:0] wdata;
  logic [15:0] dst_word;
  logic [15:0] src_word;
  logic [7:0]  src_byte;
  logic [15:0] src_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_enable <= 1'b0;
    end else if (cfg_write) begin
      exec_enable <= cfg_data;
    end
  end

  assign a_adv   = a_valid && (!o_valid || decoded.ready);
  assign a_free  = !a_valid || a_adv;
  assign code.ready = a_free;
  assign acc     = code.valid && a_free;
  assign load_a  = acc && (done || fail);

  always_comb begin
    first_byte_next  = first_byte;
    modrm_byte_next  = modrm_byte;
    disp_accum_next  = disp_accum;
    imm_accum_next   = imm_accum;
    bytes_taken_next = bytes_taken;
    np               = x86d_pkg::PH_OPCODE;
    done             = 1'b0;
    fail             = 1'b0;
    if (phase == x86d_pkg::PH_OPCODE || phase > x86d_pkg::PH_IMM_HI) begin
      first_byte_next  = code.item.code_byte;
      modrm_byte_next  = 8'd0;
      disp_accum_next  = 16'd0;
      imm_accum_next   = 16'd0;
      bytes_taken_next = 3'd1;
    end else begin
      bytes_taken_next = bytes_taken + 3'd1;
      case (phase)
        x86d_pkg::PH_MODRM:   modrm_byte_next = code.item.code_byte;
        x86d_pkg::PH_DISP_LO: disp_accum_next = {8'd0, code.item.code_byte};
        x86d_pkg::PH_DISP_HI: disp_accum_next = {code.item.code_byte, disp_accum[7:0]};
        x86d_pkg::PH_IMM_LO:  imm_accum_next  = {8'd0, code.item.code_byte};
        default:              imm_accum_next  = {code.item.code_byte, imm_accum[7:0]};
      endcase
    end
    if ((phase == x86d_pkg::PH_OPCODE || phase > x86d_pkg::PH_IMM_HI) &&
        x86d_pkg::class_of(code.item.code_byte) == x86d_pkg::CLS_ERROR) begin
      fail = 1'b1;
    end else begin
      np = x86d_pkg::next_phase(
        (phase > x86d_pkg::PH_IMM_HI) ? x86d_pkg::PH_OPCODE : phase,
        first_byte_next, modrm_byte_next);
      if (np == x86d_pkg::PH_DONE) begin
        done = 1'b1;
      end else if (code.item.last_byte) begin
        fail = 1'b1;
      end
    end
    phase_next = (done || fail) ? x86d_pkg::PH_OPCODE : np;
  end

  always_comb begin
    x86d_pkg::instr_class_t c;
    logic [1:0] dl;
    logic [7:0] op;
    logic [7:0] m;
    op = first_byte_next;
    m  = modrm_byte_next;
    c  = x86d_pkg::class_of(op);
    dl = x86d_pkg::disp_len(c, m);
    res_item = '0;
    res_req  = '0;
    res_item.instr_length = bytes_taken_next;
    if (!done) begin
      res_item.instr_class = x86d_pkg::CLS_ERROR;
    end else begin
      res_item.instr_class = c;
      if (c == x86d_pkg::CLS_ALU_RM || c == x86d_pkg::CLS_ALU_IMM_ACC) begin
        res_item.op_select = x86d_pkg::alu_code(op[5:3]);
      end else if (c == x86d_pkg::CLS_ALU_IMM_RM) begin
        res_item.op_select = x86d_pkg::alu_code(m[5:3]);
      end else if (c == x86d_pkg::CLS_JCC || c == x86d_pkg::CLS_LOOP) begin
        res_item.op_select = op[3:0];
      end
      if (c == x86d_pkg::CLS_MOV_RM || c == x86d_pkg::CLS_ALU_RM) begin
        res_item.dir_bit = op[1];
      end
      if (c == x86d_pkg::CLS_MOV_IMM_REG) begin
        res_item.wide_bit = op[3];
      end else if (c <= x86d_pkg::CLS_ALU_IMM_RM) begin
        res_item.wide_bit = op[0];
      end
      if (x86d_pkg::has_modrm(c)) begin
        res_item.mode_field = m[7:6];
        res_item.reg_field  = m[5:3];
        res_item.rm_field   = m[2:0];
      end else if (c == x86d_pkg::CLS_MOV_IMM_REG) begin
        res_item.reg_field = op[2:0];
      end
      if (dl == 2'd1) begin
        res_item.displacement = {{8{disp_accum_next[7]}}, disp_accum_next[7:0]};
      end else if (dl == 2'd2) begin
        res_item.displacement = disp_accum_next;
      end
      res_item.immediate = imm_accum_next;
      if (c == x86d_pkg::CLS_ALU_IMM_RM && op[1:0] == 2'b11 && imm_accum_next[7]) begin
        res_item.immediate = {8'hFF, imm_accum_next[7:0]};
      end
      res_req.wide = res_item.wide_bit;
      if (c == x86d_pkg::CLS_MOV_IMM_REG) begin
        res_req.wr    = exec_enable;
        res_req.dst_r = op[2:0];
      end else if (c == x86d_pkg::CLS_MOV_IMM_RM && m[7:6] == x86d_pkg::MOD_REGISTER) begin
        res_req.wr    = exec_enable;
        res_req.dst_r = m[2:0];
      end else if (c == x86d_pkg::CLS_MOV_RM && m[7:6] == x86d_pkg::MOD_REGISTER) begin
        res_req.wr         = exec_enable;
        res_req.src_is_reg = 1'b1;
        res_req.dst_r      = op[1] ? m[5:3] : m[2:0];
        res_req.src_r      = op[1] ? m[2:0] : m[5:3];
      end
    end
    res_req.dst_word = res_req.wide ? res_req.dst_r[x86d_pkg::REG_AW-1:0]
                                    : {1'b0, res_req.dst_r[1:0]};
    res_req.src_word = res_req.wide ? res_req.src_r[x86d_pkg::REG_AW-1:0]
                                    : {1'b0, res_req.src_r[1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= x86d_pkg::PH_OPCODE;
      first_byte  <= 8'd0;
      modrm_byte  <= 8'd0;
      disp_accum  <= 16'd0;
      imm_accum   <= 16'd0;
      bytes_taken <= 3'd0;
    end else if (acc) begin
      phase       <= phase_next;
      first_byte  <= first_byte_next;
      modrm_byte  <= modrm_byte_next;
      disp_accum  <= disp_accum_next;
      imm_accum   <= imm_accum_next;
      bytes_taken <= bytes_taken_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= load_a;
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_item <= res_item;
      a_req  <= res_req;
    end
  end

  assign dst_word = rok0 ? rdata0 : 16'd0;
  assign src_word = rok1 ? rdata1 : 16'd0;
  assign src_byte = a_req.src_r[2] ? src_word[15:8] : src_word[7:0];

  always_comb begin
    if (!a_req.src_is_reg) begin
      src_val = a_item.immediate;
    end else if (a_req.wide) begin
      src_val = src_word;
    end else begin
      src_val = {8'd0, src_byte};
    end
    if (a_req.wide) begin
      wdata = src_val;
    end else if (a_req.dst_r[2]) begin
      wdata = {src_val[7:0], dst_word[7:0]};
    end else begin
      wdata = {dst_word[15:8], src_val[7:0]};
    end
  end

  assign we    = a_adv && a_req.wr;
  assign waddr = a_req.dst_word;

  always_ff @(posedge clk) begin
    if (we) begin
      regs[waddr] <= wdata;
    end
    if (load_a) begin
      rdata0 <= (we && waddr == res_req.dst_word) ? wdata : regs[res_req.dst_word];
      rdata1 <= (we && waddr == res_req.src_word) ? wdata : regs[res_req.src_word];
      rok0   <= (we && waddr == res_req.dst_word) || reg_valid[res_req.dst_word];
      rok1   <= (we && waddr == res_req.src_word) || reg_valid[res_req.src_word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (we) begin
      reg_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_adv) begin
      o_valid <= 1'b1;
    end else if (decoded.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_comb begin
    a_out               = a_item;
    a_out.reg_written   = a_req.wr;
    a_out.written_value = a_req.wr ? wdata : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      o_item <= a_out;
    end
  end

  assign decoded.valid = o_valid;
  assign decoded.item  = o_item;

endmodule

### tb/x86d_decode_checker.sv
module x86d_decode_checker
  import x86d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  logic      code_valid,
  input  logic      code_ready,
  input  in_item_t  code_item,
  input  logic      dec_valid,
  input  logic      dec_ready,
  input  out_item_t dec_item,
  output int        errors,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  instr_bytes [0:5];
  int          taken;
  logic [15:0] gpr [0:7];
  logic        exec_on;
  out_item_t   expected_q[$];
  out_item_t   want;
  int          fail_n;
  int          seen_n;

  function automatic instr_class_t classify(logic [7:0] op);
    casez (op)
      8'b100010??: return CLS_MOV_RM;
      8'b1011????: return CLS_MOV_IMM_REG;
      8'b1100011?: return CLS_MOV_IMM_RM;
      8'b00???0??: return CLS_ALU_RM;
      8'b00???1??: return CLS_ALU_IMM_ACC;
      8'b100000??: return CLS_ALU_IMM_RM;
      8'b0111????: return CLS_JCC;
      8'b111000??: return CLS_LOOP;
      default: return CLS_ERROR;
    endcase
  endfunction

  function automatic int modrm_size(instr_class_t c);
    case (c)
      CLS_MOV_RM, CLS_MOV_IMM_RM, CLS_ALU_RM, CLS_ALU_IMM_RM: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int disp_size(instr_class_t c, logic [7:0] m);
    if (c == CLS_JCC || c == CLS_LOOP) return 1;
    if (modrm_size(c) == 0) return 0;
    case (m[7:6])
      MOD_DISP8: return 1;
      MOD_DISP16: return 2;
      MOD_MEM_NODISP: return (m[2:0] == RM_DIRECT) ? 2 : 0;
      default: return 0;
    endcase
  endfunction

  function automatic int imm_size(instr_class_t c, logic [7:0] op);
    case (c)
      CLS_MOV_IMM_REG: return op[3] ? 2 : 1;
      CLS_MOV_IMM_RM, CLS_ALU_IMM_ACC: return op[0] ? 2 : 1;
      CLS_ALU_IMM_RM: return (op[1:0] == 2'b01) ? 2 : 1;
      default: return 0;
    endcase
  endfunction

  function automatic alu_sel_t alu_kind(logic [2:0] f);
    if (f == ALU_FIELD_ADD) return ALU_ADD;
    if (f == ALU_FIELD_SUB) return ALU_SUB;
    if (f == ALU_FIELD_CMP) return ALU_CMP;
    return ALU_OTHER;
  endfunction

  function automatic logic [15:0] reg_value(logic [2:0] r, logic w);
    if (w) return gpr[r];
    return r[2] ? {8'h00, gpr[r[1:0]][15:8]} : {8'h00, gpr[r[1:0]][7:0]};
  endfunction

  task automatic reg_store(input logic [2:0] r, input logic w, input logic [15:0] v,
                           output logic [15:0] now);
    if (w) gpr[r] = v;
    else if (r[2]) gpr[r[1:0]][15:8] = v[7:0];
    else gpr[r[1:0]][7:0] = v[7:0];
    now = gpr[w ? r : {1'b0, r[1:0]}];
  endtask

  task automatic finish_instr(output out_item_t res);
    instr_class_t c;
    logic [7:0]   op;
    logic [7:0]   m;
    logic [7:0]   b;
    logic [15:0]  nv;
    int           pos;
    int           dn;
    int           inum;
    res = '0;
    op = instr_bytes[0];
    c = classify(op);
    m = 8'h00;
    pos = 1;
    if (modrm_size(c) == 1) begin
      m = instr_bytes[1];
      pos = 2;
      {res.mode_field, res.reg_field, res.rm_field} = m;
    end
    dn = disp_size(c, m);
    inum = imm_size(c, op);
    res.instr_class = c;
    case (c)
      CLS_ALU_RM, CLS_ALU_IMM_ACC: res.op_select = alu_kind(op[5:3]);
      CLS_ALU_IMM_RM: res.op_select = alu_kind(m[5:3]);
      CLS_JCC, CLS_LOOP: res.op_select = op[3:0];
      default: ;
    endcase
    if (c == CLS_MOV_RM || c == CLS_ALU_RM) res.dir_bit = op[1];
    if (c == CLS_MOV_IMM_REG) begin
      res.wide_bit = op[3];
      res.reg_field = op[2:0];
    end else if (c <= CLS_ALU_IMM_RM) begin
      res.wide_bit = op[0];
    end
    if (dn == 1) res.displacement = {{8{instr_bytes[pos][7]}}, instr_bytes[pos]};
    else if (dn == 2) res.displacement = {instr_bytes[pos + 1], instr_bytes[pos]};
    pos += dn;
    b = instr_bytes[pos];
    if (inum == 2) res.immediate = {instr_bytes[pos + 1], b};
    else if (inum == 1 && c == CLS_ALU_IMM_RM && op[1:0] == 2'b11)
      res.immediate = {{8{b[7]}}, b};
    else if (inum == 1) res.immediate = {8'h00, b};
    res.instr_length = 3'(taken);
    if (exec_on) begin
      if (c == CLS_MOV_IMM_REG) begin
        reg_store(op[2:0], res.wide_bit, res.immediate, nv);
        res.reg_written = 1'b1;
      end else if (c == CLS_MOV_IMM_RM && m[7:6] == MOD_REGISTER) begin
        reg_store(m[2:0], res.wide_bit, res.immediate, nv);
        res.reg_written = 1'b1;
      end else if (c == CLS_MOV_RM && m[7:6] == MOD_REGISTER) begin
        if (op[1]) reg_store(m[5:3], op[0], reg_value(m[2:0], op[0]), nv);
        else reg_store(m[2:0], op[0], reg_value(m[5:3], op[0]), nv);
        res.reg_written = 1'b1;
      end
      if (res.reg_written) res.written_value = nv;
    end
  endtask

  task automatic take_byte(input in_item_t it);
    instr_class_t c;
    out_item_t    res;
    int           total;
    instr_bytes[taken] = it.code_byte;
    taken++;
    c = classify(instr_bytes[0]);
    total = 0;
    if (c != CLS_ERROR && taken > modrm_size(c))
      total = 1 + modrm_size(c) + disp_size(c, instr_bytes[1]) + imm_size(c, instr_bytes[0]);
    if (c != CLS_ERROR && taken == total) begin
      finish_instr(res);
      expected_q.push_back(res);
      taken = 0;
    end else if (c == CLS_ERROR || it.last_byte) begin
      res = '0;
      res.instr_class = CLS_ERROR;
      res.instr_length = 3'(taken);
      expected_q.push_back(res);
      taken = 0;
    end
  endtask

  task automatic match_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fail_n++;
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      taken = 0;
      exec_on = 1'b0;
      foreach (gpr[i]) gpr[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_write) exec_on = cfg_data;
      if (code_valid && code_ready) take_byte(code_item);
      if (dec_valid && dec_ready) begin
        if (expected_q.size() == 0) begin
          fail_n++;
          $display("%0t unexpected result: expected none actual class %0d", $time,
                   dec_item.instr_class);
        end else begin
          want = expected_q.pop_front();
          seen_n++;
          match_field("instr_class", want.instr_class, dec_item.instr_class);
          match_field("op_select", want.op_select, dec_item.op_select);
          match_field("dir_bit", want.dir_bit, dec_item.dir_bit);
          match_field("wide_bit", want.wide_bit, dec_item.wide_bit);
          match_field("mode_field", want.mode_field, dec_item.mode_field);
          match_field("reg_field", want.reg_field, dec_item.reg_field);
          match_field("rm_field", want.rm_field, dec_item.rm_field);
          match_field("displacement", want.displacement, dec_item.displacement);
          match_field("immediate", want.immediate, dec_item.immediate);
          match_field("instr_length", want.instr_length, dec_item.instr_length);
          match_field("reg_written", want.reg_written, dec_item.reg_written);
          match_field("written_value", want.written_value, dec_item.written_value);
        end
      end
    end
    errors <= fail_n;
    pending <= expected_q.size();
    checked <= seen_n;
  end

endmodule

### tb/tb_x86_16_instruction_decoder_core.sv
module tb_x86_16_instruction_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import x86d_pkg::*;

  localparam int PERIOD      = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;
  int   errors;
  int   pending;
  int   checked;
  int   sent_bytes = 0;
  int   cycles = 0;
  bit   src_gaps;
  bit   sink_gaps;
  bit   sink_hold;

  x86d_in_if  code ();
  x86d_out_if decoded ();

  x86_16_instruction_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .code      (code),
    .decoded   (decoded)
  );

  x86d_decode_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .code_valid (code.valid),
    .code_ready (code.ready),
    .code_item  (code.item),
    .dec_valid  (decoded.valid),
    .dec_ready  (decoded.ready),
    .dec_item   (decoded.item),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: long hold-off on request, else random stall bursts if sink_gaps is set
  initial begin
    decoded.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        decoded.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
        decoded.ready <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        decoded.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        decoded.ready <= 1'b1;
      end else begin
        decoded.ready <= 1'b1;
      end
    end
  end

  // offer one byte, return at the edge where the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      code.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    code.valid <= 1'b1;
    code.item <= {b, lst};
    @(posedge clk);
    while (!code.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_instr(input bit cut);
    logic [7:0] seq[$];
    logic [7:0] op;
    logic [7:0] m;
    logic [7:0] b;
    int         nd;
    int         ni;
    int         stop;
    bit         rm_used;
    m = $urandom;
    if ($urandom_range(0, 1) == 0) m[7:6] = MOD_REGISTER;
    nd = 0;
    ni = 0;
    rm_used = 1'b1;
    case ($urandom_range(0, 7))
      0: op = {MOV_RM_PREFIX, 2'($urandom)};
      1: begin
        op = {MOV_IMM_REG_PFX, 4'($urandom)};
        rm_used = 1'b0;
        ni = op[3] ? 2 : 1;
      end
      2: begin
        op = {MOV_IMM_RM_PFX, 1'($urandom)};
        ni = op[0] ? 2 : 1;
      end
      3: op = {2'b00, 3'($urandom), 1'b0, 2'($urandom)};
      4: begin
        op = {2'b00, 3'($urandom), 1'b1, 2'($urandom)};
        rm_used = 1'b0;
        ni = op[0] ? 2 : 1;
      end
      5: begin
        op = {ALU_IMM_RM_PFX, 2'($urandom)};
        ni = (op[1:0] == 2'b01) ? 2 : 1;
      end
      6: begin
        op = {JCC_PREFIX, 4'($urandom)};
        rm_used = 1'b0;
        nd = 1;
      end
      default: begin
        op = {LOOP_PREFIX, 2'b00, 2'($urandom)};
        rm_used = 1'b0;
        nd = 1;
      end
    endcase
    seq.push_back(op);
    if (rm_used) begin
      seq.push_back(m);
      if (m[7:6] == MOD_DISP8) nd = 1;
      else if (m[7:6] == MOD_DISP16 || (m[7:6] == MOD_MEM_NODISP && m[2:0] == RM_DIRECT))
        nd = 2;
    end
    repeat (nd + ni) begin
      b = $urandom;
      if ($urandom_range(0, 3) == 0) b = {b[7], {7{b[6]}}};
      seq.push_back(b);
    end
    stop = cut ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < stop; i++)
      send_byte(seq[i], (i == stop - 1) && (cut || $urandom_range(0, 9) == 0));
  endtask

  task automatic drain();
    code.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_exec(input logic v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int start;
    int pick;
    start = sent_bytes;
    while (sent_bytes - start < quota) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) send_instr(1'b0);
      else if (pick == 8) send_instr(1'b1);
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
    // close any partial instruction so the decoder is back at an opcode
    send_byte(8'($urandom), 1'b1);
    drain();
  endtask

  initial begin
    logic [8:0] directed[$];
    directed = '{9'h0FF,
                 9'h08B, 9'h006, 9'h034, 9'h012,
                 9'h0B4, 9'h07F,
                 9'h0B0, 9'h080,
                 9'h088, 9'h0E3,
                 9'h0C6, 9'h0C1, 9'h0FF,
                 9'h081, 9'h0BE, 9'h000, 9'h080, 9'h0FF, 9'h0FF,
                 9'h075, 9'h080,
                 9'h0B8, 9'h112};
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    code.valid <= 1'b0;
    code.item <= '0;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_exec(1'b1);
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    run_phase(400);

    // hold the result side while bytes keep coming, then wait it out
    set_exec(1'b0);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = 1'b1;
    repeat (25) send_instr(1'b0);
    drain();
    src_gaps = 1'b1;
    run_phase(300);

    set_exec(1'b1);
    src_gaps = 1'b0;
    sink_gaps = 1'b1;
    run_phase(400);

    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    run_phase(400);

    $display("Sent %0d code bytes: directed cases, whole, cut and noisy streams,", sent_bytes);
    $display("execution on and off, a %0d-cycle result hold-off; %0d results compared.",
             HOLD_CYCLES, checked);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### x86_16_instruction_decoder_core.f
rtl/x86d_pkg.sv
rtl/x86d_ifs.sv
rtl/x86_16_instruction_decoder_core.sv
tb/x86d_decode_checker.sv
tb/tb_x86_16_instruction_decoder_core.sv
